### rtl/nss_pkg.sv
// shared types, widths and codes of the note step sequencer
`timescale 1ns / 1ps
`default_nettype none

package nss_pkg;

    localparam int MAX_STEPS = 64;
    localparam int IDX_W     = $clog2(MAX_STEPS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int PITCH_W   = 16;
    localparam int BEATS_W   = 8;
    localparam int PICK_W    = 6;
    localparam int FUNC_W    = 3;
    localparam int KIND_W    = 2;
    localparam int STYLE_W   = 2;
    localparam int IN_DATA_W = 48;
    localparam int DIV_W     = (CNT_W > PICK_W) ? CNT_W : PICK_W;
    localparam int BITCNT_W  = $clog2(DIV_W);

    typedef enum logic [FUNC_W-1:0] {
        FN_BEAT  = 3'd0,
        FN_PUSH  = 3'd1,
        FN_POP   = 3'd2,
        FN_CLEAR = 3'd3,
        FN_START = 3'd4,
        FN_STOP  = 3'd5
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_ON      = 2'd0,
        KIND_OFF     = 2'd1,
        KIND_ALL_OFF = 2'd2
    } t_kind;

    typedef enum logic [STYLE_W-1:0] {
        STYLE_FWD  = 2'd0,
        STYLE_BWD  = 2'd1,
        STYLE_RAND = 2'd2
    } t_style;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_TOP,
        RD_MOD
    } t_rd_sel;

    typedef enum logic [1:0] {
        SRC_READ,
        SRC_HELD,
        SRC_ZERO
    } t_out_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_BEAT_CHK,
        S_MOD_WAIT,
        S_NEW_CHK,
        S_OFF_EMIT,
        S_ON_EMIT,
        S_POP_CHK,
        S_POP_EMIT,
        S_STOP_EMIT
    } t_state;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic               rest;
        logic [BEATS_W-1:0] beats;
    } t_step;

    typedef struct packed {
        logic     capture;
        logic     push;
        logic     pop;
        logic     clear;
        logic     start;
        logic     stop;
        logic     beats_dec;
        logic     beats_clr;
        logic     beats_load;
        logic     off_latch;
        logic     mod_start;
        logic     idx_load;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     out_load;
        t_kind    out_kind;
        t_out_src out_src;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              playing;
        logic              pop_hit;
        logic              beats_gt1;
        logic              off_pend;
        logic              rd_rest;
        logic              mod_busy;
        logic              out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/nss_mod.sv
// iterative remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module nss_mod (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [nss_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [nss_pkg::CNT_W-1:0] i_divisor,
    output logic                           o_busy,
    output logic [nss_pkg::IDX_W-1:0]      o_rem
);

    logic                         r_busy;
    logic [nss_pkg::BITCNT_W-1:0] r_bit;
    logic [nss_pkg::DIV_W-1:0]    r_dvd;
    logic [nss_pkg::IDX_W-1:0]    r_rem;
    logic [nss_pkg::CNT_W-1:0]    shifted;
    logic [nss_pkg::CNT_W-1:0]    diff;
    logic [nss_pkg::IDX_W-1:0]    n_rem;

    // remainder stays below the divisor, so it fits the index width
    always_comb begin
        shifted = {r_rem, r_dvd[nss_pkg::DIV_W-1]};
        diff    = shifted - i_divisor;
        if (shifted >= i_divisor) begin
            n_rem = diff[nss_pkg::IDX_W-1:0];
        end else begin
            n_rem = shifted[nss_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_bit <= nss_pkg::BITCNT_W'(nss_pkg::DIV_W - 1);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[nss_pkg::DIV_W-2:0], 1'b0};
            r_bit <= r_bit - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### rtl/nss_dp.sv
// datapath: step table, play state, remainder unit and result register
`timescale 1ns / 1ps
`default_nettype none

module nss_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire nss_pkg::t_dp_cmd            i_cmd,
    output nss_pkg::t_dp_stat                o_stat,
    input  wire logic [nss_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [nss_pkg::PITCH_W-1:0] i_step_pitch,
    input  wire logic                        i_step_is_rest,
    input  wire logic [nss_pkg::BEATS_W-1:0] i_step_beats,
    input  wire logic [nss_pkg::PITCH_W-1:0] i_start_offset,
    input  wire logic [nss_pkg::PICK_W-1:0]  i_random_pick,
    input  wire logic                        i_cfg_we,
    input  wire logic [nss_pkg::STYLE_W-1:0] i_cfg_style,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [nss_pkg::KIND_W-1:0]       o_out_kind,
    output logic [nss_pkg::PITCH_W-1:0]      o_out_pitch,
    output logic                             o_out_last
);

    // captured request
    logic [nss_pkg::FUNC_W-1:0]  r_func;
    logic [nss_pkg::PITCH_W-1:0] r_pitch;
    logic                        r_rest;
    logic [nss_pkg::BEATS_W-1:0] r_beats;
    logic [nss_pkg::PITCH_W-1:0] r_offset_in;
    logic [nss_pkg::PICK_W-1:0]  r_pick;

    // play state
    logic [nss_pkg::CNT_W-1:0]   r_count;
    logic [nss_pkg::IDX_W-1:0]   r_idx;
    logic                        r_idx_none;
    logic [nss_pkg::BEATS_W-1:0] r_beats_left;
    logic                        r_playing;
    logic [nss_pkg::PITCH_W-1:0] r_offset;
    logic [nss_pkg::STYLE_W-1:0] r_style;
    logic                        r_off_pend;
    logic [nss_pkg::PITCH_W-1:0] r_off_pitch;

    logic [$bits(nss_pkg::t_step)-1:0] mem [nss_pkg::MAX_STEPS];
    nss_pkg::t_step                    r_rd;
    nss_pkg::t_step                    wr_step;
    logic [nss_pkg::IDX_W-1:0]         rd_addr;

    logic                        r_out_valid;
    logic [nss_pkg::KIND_W-1:0]  r_out_kind;
    logic [nss_pkg::PITCH_W-1:0] r_out_pitch;
    logic                        r_out_last;

    logic [nss_pkg::DIV_W-1:0]   dividend;
    logic                        mod_busy;
    logic [nss_pkg::IDX_W-1:0]   mod_rem;
    logic [nss_pkg::PITCH_W:0]   sum;
    logic [nss_pkg::PITCH_W-1:0] sat_pitch;
    logic                        in_range;
    logic                        out_free;
    logic [nss_pkg::CNT_W-1:0]   top;

    assign top      = r_count - 1'b1;
    assign in_range = !r_idx_none && (nss_pkg::CNT_W'(r_idx) < r_count);
    assign out_free = !r_out_valid || i_out_ready;

    // step pitch plus offset, exact in one extra bit, then clamped
    always_comb begin
        sum = {r_rd.pitch[nss_pkg::PITCH_W-1], r_rd.pitch}
            + {r_offset[nss_pkg::PITCH_W-1], r_offset};
        if (sum[nss_pkg::PITCH_W] != sum[nss_pkg::PITCH_W-1]) begin
            sat_pitch = sum[nss_pkg::PITCH_W]
                      ? {1'b1, {(nss_pkg::PITCH_W-1){1'b0}}}
                      : {1'b0, {(nss_pkg::PITCH_W-1){1'b1}}};
        end else begin
            sat_pitch = sum[nss_pkg::PITCH_W-1:0];
        end
    end

    always_comb begin
        case (r_style)
            nss_pkg::STYLE_BWD: begin
                if (r_idx_none) begin
                    dividend = nss_pkg::DIV_W'(top);
                end else begin
                    dividend = nss_pkg::DIV_W'(r_idx) + nss_pkg::DIV_W'(top);
                end
            end
            nss_pkg::STYLE_RAND: dividend = nss_pkg::DIV_W'(r_pick);
            default: begin
                if (r_idx_none) begin
                    dividend = '0;
                end else begin
                    dividend = nss_pkg::DIV_W'(r_idx) + 1'b1;
                end
            end
        endcase
    end

    nss_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (dividend),
        .i_divisor  (r_count),
        .o_busy     (mod_busy),
        .o_rem      (mod_rem)
    );

    always_comb begin
        unique case (i_cmd.rd_sel)
            nss_pkg::RD_CUR: rd_addr = r_idx;
            nss_pkg::RD_TOP: rd_addr = top[nss_pkg::IDX_W-1:0];
            nss_pkg::RD_MOD: rd_addr = mod_rem;
            default:         rd_addr = r_idx;
        endcase
    end

    // a zero length plays as one beat
    always_comb begin
        wr_step.pitch = r_pitch;
        wr_step.rest  = r_rest;
        wr_step.beats = (r_beats == '0) ? nss_pkg::BEATS_W'(1) : r_beats;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_count[nss_pkg::IDX_W-1:0]] <= wr_step;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func      <= i_func;
            r_pitch     <= i_step_pitch;
            r_rest      <= i_step_is_rest;
            r_beats     <= i_step_beats;
            r_offset_in <= i_start_offset;
            r_pick      <= i_random_pick;
        end
        if (i_cmd.off_latch) begin
            r_off_pitch <= sat_pitch;
        end
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_last <= i_cmd.out_last;
            unique case (i_cmd.out_src)
                nss_pkg::SRC_READ: r_out_pitch <= sat_pitch;
                nss_pkg::SRC_HELD: r_out_pitch <= r_off_pitch;
                default:           r_out_pitch <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idx        <= '0;
            r_idx_none   <= 1'b1;
            r_beats_left <= '0;
            r_playing    <= 1'b0;
            r_offset     <= '0;
            r_style      <= nss_pkg::STYLE_FWD;
            r_off_pend   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_style <= i_cfg_style;
            end
            if (i_cmd.push) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop) begin
                r_count <= top;
            end else if (i_cmd.clear) begin
                r_count <= '0;
            end
            if (i_cmd.start) begin
                r_offset  <= r_offset_in;
                r_playing <= 1'b1;
            end else if (i_cmd.stop) begin
                r_playing <= 1'b0;
            end
            if (i_cmd.stop) begin
                r_idx_none <= 1'b1;
            end else if (i_cmd.idx_load) begin
                r_idx      <= mod_rem;
                r_idx_none <= 1'b0;
            end
            if (i_cmd.stop || i_cmd.beats_clr) begin
                r_beats_left <= '0;
            end else if (i_cmd.beats_dec) begin
                r_beats_left <= r_beats_left - 1'b1;
            end else if (i_cmd.beats_load) begin
                r_beats_left <= r_rd.beats;
            end
            // note-off only for a sounding step whose count runs out now
            if (i_cmd.off_latch) begin
                r_off_pend <= in_range && !r_rd.rest
                              && (r_beats_left == nss_pkg::BEATS_W'(1));
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.func      = r_func;
        o_stat.full      = (r_count == nss_pkg::CNT_W'(nss_pkg::MAX_STEPS));
        o_stat.empty     = (r_count == '0);
        o_stat.playing   = r_playing;
        o_stat.pop_hit   = r_playing && !r_idx_none && (nss_pkg::CNT_W'(r_idx) == top);
        o_stat.beats_gt1 = (r_beats_left > nss_pkg::BEATS_W'(1));
        o_stat.off_pend  = r_off_pend;
        o_stat.rd_rest   = r_rd.rest;
        o_stat.mod_busy  = mod_busy;
        o_stat.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_pitch = r_out_pitch;
    assign o_out_last  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= nss_pkg::CNT_W'(nss_pkg::MAX_STEPS))
        else $error("step count above table size");

    a_beats_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beats_left != '0) |-> r_playing)
        else $error("beats left while stopped");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_playing |-> r_idx_none)
        else $error("index held while stopped");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result register overwritten");

    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(mod_busy) |-> (nss_pkg::CNT_W'(mod_rem) < r_count))
        else $error("remainder not below step count");

endmodule

`default_nettype wire

### rtl/nss_ctrl.sv
// controller state machine: decodes requests and sequences the datapath
`timescale 1ns / 1ps
`default_nettype none

module nss_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire nss_pkg::t_dp_stat i_stat,
    output nss_pkg::t_dp_cmd       o_cmd
);

    nss_pkg::t_state r_state;
    nss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            nss_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = nss_pkg::S_DISPATCH;
                end
            end
            nss_pkg::S_DISPATCH: begin
                n_state = nss_pkg::S_IDLE;
                unique case (i_stat.func)
                    nss_pkg::FN_BEAT: begin
                        if (i_stat.playing && !i_stat.empty) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = nss_pkg::RD_CUR;
                            n_state      = nss_pkg::S_BEAT_CHK;
                        end
                    end
                    nss_pkg::FN_PUSH: o_cmd.push = !i_stat.full;
                    nss_pkg::FN_POP: begin
                        if (!i_stat.empty) begin
                            if (i_stat.pop_hit) begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = nss_pkg::RD_TOP;
                                n_state      = nss_pkg::S_POP_CHK;
                            end else begin
                                o_cmd.pop = 1'b1;
                            end
                        end
                    end
                    nss_pkg::FN_CLEAR: o_cmd.clear = 1'b1;
                    nss_pkg::FN_START: o_cmd.start = !i_stat.playing;
                    nss_pkg::FN_STOP: begin
                        if (i_stat.playing) begin
                            o_cmd.stop = 1'b1;
                            n_state    = nss_pkg::S_STOP_EMIT;
                        end
                    end
                    default: ;
                endcase
            end
            nss_pkg::S_BEAT_CHK: begin
                o_cmd.off_latch = 1'b1;
                if (i_stat.beats_gt1) begin
                    o_cmd.beats_dec = 1'b1;
                    n_state         = nss_pkg::S_IDLE;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = nss_pkg::S_MOD_WAIT;
                end
            end
            nss_pkg::S_MOD_WAIT: begin
                if (!i_stat.mod_busy) begin
                    o_cmd.idx_load = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = nss_pkg::RD_MOD;
                    n_state        = nss_pkg::S_NEW_CHK;
                end
            end
            nss_pkg::S_NEW_CHK: begin
                o_cmd.beats_load = 1'b1;
                if (i_stat.off_pend) begin
                    n_state = nss_pkg::S_OFF_EMIT;
                end else if (!i_stat.rd_rest) begin
                    n_state = nss_pkg::S_ON_EMIT;
                end else begin
                    n_state = nss_pkg::S_IDLE;
                end
            end
            nss_pkg::S_OFF_EMIT: begin
                // the note-off is last only when the new step is a rest
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = nss_pkg::KIND_OFF;
                    o_cmd.out_src  = nss_pkg::SRC_HELD;
                    o_cmd.out_last = i_stat.rd_rest;
                    n_state = i_stat.rd_rest ? nss_pkg::S_IDLE : nss_pkg::S_ON_EMIT;
                end
            end
            nss_pkg::S_ON_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = nss_pkg::KIND_ON;
                    o_cmd.out_src  = nss_pkg::SRC_READ;
                    o_cmd.out_last = 1'b1;
                    n_state        = nss_pkg::S_IDLE;
                end
            end
            nss_pkg::S_POP_CHK: begin
                o_cmd.pop       = 1'b1;
                o_cmd.beats_clr = 1'b1;
                n_state = i_stat.rd_rest ? nss_pkg::S_IDLE : nss_pkg::S_POP_EMIT;
            end
            nss_pkg::S_POP_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = nss_pkg::KIND_OFF;
                    o_cmd.out_src  = nss_pkg::SRC_READ;
                    o_cmd.out_last = 1'b1;
                    n_state        = nss_pkg::S_IDLE;
                end
            end
            nss_pkg::S_STOP_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = nss_pkg::KIND_ALL_OFF;
                    o_cmd.out_src  = nss_pkg::SRC_ZERO;
                    o_cmd.out_last = 1'b1;
                    n_state        = nss_pkg::S_IDLE;
                end
            end
            default: n_state = nss_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### rtl/note_step_sequencer_unit.sv
// Table edits, start, ignored requests and a stop while stopped return to ready after
// the dispatch state; a stop while playing also emits an all-off, a pop of the playing
// step reads the top step and emits its note-off unless it is a rest. A beat that moves
// the step runs the bit-serial remainder unit, then reads the new step and emits events.
// Results leave through a register, so the next request is taken while one waits.
// Synchronous active-low reset clears all control and play state; the step
// table contents are not cleared and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module note_step_sequencer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // step_pitch[15:0], step_is_rest[16], step_beats[24:17],
    // start_offset[40:25], random_pick[46:41], zero[47]
    input  wire logic [nss_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // func[2:0]
    input  wire logic [nss_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // note_pitch[15:0]
    output logic [nss_pkg::PITCH_W-1:0]        m_axis_tdata,
    // event_kind[1:0]
    output logic [nss_pkg::KIND_W-1:0]         m_axis_tuser,
    output logic                               m_axis_tlast,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [nss_pkg::STYLE_W-1:0]   i_cfg_data
);

    nss_pkg::t_dp_cmd  cmd;
    nss_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    nss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nss_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_func         (s_axis_tuser),
        .i_step_pitch   (s_axis_tdata[15:0]),
        .i_step_is_rest (s_axis_tdata[16]),
        .i_step_beats   (s_axis_tdata[24:17]),
        .i_start_offset (s_axis_tdata[40:25]),
        .i_random_pick  (s_axis_tdata[46:41]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_style    (i_cfg_data),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_kind     (m_axis_tuser),
        .o_out_pitch    (m_axis_tdata),
        .o_out_last     (m_axis_tlast)
    );

endmodule

`default_nettype wire
